/* rtl/sbhit_pkg.sv */
// ----------------------------------------------------------------------------
// sbhit_pkg
// Shared widths, constants and types of the swept box hit test pipeline.
// ----------------------------------------------------------------------------
package sbhit_pkg;

	localparam int CW     = 24;            // coordinate width, signed Q16.8
	localparam int SW     = CW - 1;        // size width, unsigned
	localparam int TF     = 16;            // time fraction bits
	localparam int TW     = 24;            // reported time width, signed Q8.16
	localparam int NUM_W  = CW + 2;        // slab numerator, signed
	localparam int AW     = NUM_W - 1;     // numerator magnitude
	localparam int DW     = CW;            // divisor magnitude
	localparam int QW     = AW + TF + 1;   // dividend and quotient width
	localparam int TV_W   = QW + 3;        // signed time with room for infinity
	localparam int PW     = TW + CW;       // time times displacement
	localparam int RW     = PW - TF + 2;   // rounded offset, signed
	localparam int CS_W   = RW + 1;        // contact before saturation
	localparam int NT     = 4;             // near x, far x, near y, far y
	localparam int IN_W   = 240;
	localparam int OUT_W  = 80;

	localparam logic [2:0] NORM_NONE = 3'd0;
	localparam logic [2:0] NORM_POS_X = 3'd1;
	localparam logic [2:0] NORM_NEG_X = 3'd2;
	localparam logic [2:0] NORM_POS_Y = 3'd3;
	localparam logic [2:0] NORM_NEG_Y = 3'd4;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [TV_W-1:0] tval_t;
	typedef logic signed [TW-1:0] time_t;

	localparam tval_t T_INF  = {1'b0, {(TV_W-1){1'b1}}};
	localparam tval_t T_ONE  = tval_t'(longint'(1) << TF);
	localparam tval_t TH_MAX = tval_t'((longint'(1) << (TW - 1)) - 1);
	localparam tval_t TH_MIN = tval_t'(-(longint'(1) << (TW - 1)));
	localparam logic signed [CS_W-1:0] C_MAX = CS_W'((longint'(1) << (CW - 1)) - 1);
	localparam logic signed [CS_W-1:0] C_MIN = CS_W'(-(longint'(1) << (CW - 1)));

	typedef struct packed {
		logic neg;
		logic dzero;
		logic nzero;
	} tinfo_t;

	typedef struct packed {
		coord_t mx;
		coord_t my;
		coord_t dx;
		coord_t dy;
		tinfo_t [NT-1:0] ti;
	} side_t;

	typedef struct packed {
		logic hit;
		time_t th;
		coord_t mx;
		coord_t my;
		coord_t dx;
		coord_t dy;
		logic [2:0] normal;
	} sel_t;

	typedef struct packed {
		logic hit;
		time_t th;
		coord_t cx;
		coord_t cy;
		logic [2:0] normal;
	} res_t;

endpackage

/* rtl/swept_box_vs_box_hit_test.sv */
// ----------------------------------------------------------------------------
// swept_box_vs_box_hit_test
// Swept box against fixed box, slab method, one box pair per clock unless m_axis stalls.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one box pair per transaction (mover corner, size,
//   displacement, fixed box corner and size); m_axis returns one result per
//   pair in the same order (hit, entry time, contact corner, face normal).
//   the path from input transaction to m_axis_tvalid runs through one stage
//   of numerator setup, 42 stages of divider (one quotient bit per stage),
//   two stages of interval logic and two of contact math.
//   throughput is one pair per cycle unless m_axis stalls; the 42-stage
//   divider is replicated for each of the four slab times and the contact
//   multiplier for each axis, so every stage takes a new pair.
//   the last stage is the output register. when m_axis_tready is low with a
//   result shown, the whole pipeline holds and s_axis_tready drops; nothing
//   is lost or repeated. an empty output register lets the pipeline move.
//   reset clears all valid bits, so the pipeline comes up empty.
// ----------------------------------------------------------------------------
module swept_box_vs_box_hit_test (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// mover_x, mover_y, mover_w, mover_h, move_dx, move_dy, box_x, box_y,
	// box_w, box_h, zero pad
	input  logic [sbhit_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// hit, hit_time, contact_x, contact_y, normal_code, zero pad
	output logic [sbhit_pkg::OUT_W-1:0]   m_axis_tdata
);

	logic en;
	logic valid_s1;
	sbhit_pkg::side_t side_s1;
	logic [sbhit_pkg::NT-1:0][sbhit_pkg::QW-1:0] dvd_s1;
	logic [1:0][sbhit_pkg::DW-1:0] dvs_s1;
	logic [sbhit_pkg::NT-1:0][sbhit_pkg::QW-1:0] quo;

	logic dly_valid_s [sbhit_pkg::QW];
	sbhit_pkg::side_t dly_side_s [sbhit_pkg::QW];

	logic valid_s3;
	sbhit_pkg::sel_t sel_s3;
	logic valid_s5;
	sbhit_pkg::res_t res_s5;

	assign en = !valid_s5 || m_axis_tready;
	assign s_axis_tready = en;

	sbhit_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.in_data  (s_axis_tdata),
		.valid_s1 (valid_s1),
		.side_s1  (side_s1),
		.dvd_s1   (dvd_s1),
		.dvs_s1   (dvs_s1)
	);

	for (genvar k = 0; k < sbhit_pkg::NT; k++) begin : g_div
		sbhit_div_pipe u_div (
			.clk (clk),
			.en  (en),
			.dvd (dvd_s1[k]),
			.dvs (dvs_s1[k / 2]),
			.quo (quo[k])
		);
	end

	// side data rides alongside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sbhit_pkg::QW; i++) begin
				dly_valid_s[i] <= 1'b0;
			end
		end else if (en) begin
			dly_valid_s[0] <= valid_s1;
			for (int i = 1; i < sbhit_pkg::QW; i++) begin
				dly_valid_s[i] <= dly_valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dly_side_s[0] <= side_s1;
			for (int i = 1; i < sbhit_pkg::QW; i++) begin
				dly_side_s[i] <= dly_side_s[i-1];
			end
		end
	end

	sbhit_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (dly_valid_s[sbhit_pkg::QW-1]),
		.side     (dly_side_s[sbhit_pkg::QW-1]),
		.quo      (quo),
		.valid_s3 (valid_s3),
		.sel_s3   (sel_s3)
	);

	sbhit_contact u_contact (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s3),
		.sel      (sel_s3),
		.valid_s5 (valid_s5),
		.res_s5   (res_s5)
	);

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = {4'b0000, res_s5.normal, res_s5.cy, res_s5.cx, res_s5.th, res_s5.hit};

endmodule

/* rtl/sbhit_prep.sv */
// ----------------------------------------------------------------------------
// sbhit_prep
// First stage: slab numerators, magnitudes and rounded dividends.
// ----------------------------------------------------------------------------
module sbhit_prep (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [sbhit_pkg::IN_W-1:0]             in_data,
	output logic                                   valid_s1,
	output sbhit_pkg::side_t                       side_s1,
	output logic [sbhit_pkg::NT-1:0][sbhit_pkg::QW-1:0] dvd_s1,
	output logic [1:0][sbhit_pkg::DW-1:0]          dvs_s1
);

	sbhit_pkg::coord_t mx, my, dx, dy, bx, by;
	logic [sbhit_pkg::SW-1:0] mw, mh, bw, bh;
	logic signed [sbhit_pkg::NUM_W-1:0] num [sbhit_pkg::NT];
	logic [sbhit_pkg::DW-1:0] ud [2];
	logic [sbhit_pkg::NT-1:0][sbhit_pkg::QW-1:0] dvd;
	sbhit_pkg::side_t side;

	assign mx = in_data[23:0];
	assign my = in_data[47:24];
	assign mw = in_data[70:48];
	assign mh = in_data[93:71];
	assign dx = in_data[117:94];
	assign dy = in_data[141:118];
	assign bx = in_data[165:142];
	assign by = in_data[189:166];
	assign bw = in_data[212:190];
	assign bh = in_data[235:213];

	always_comb begin
		logic [sbhit_pkg::AW-1:0] mag;
		logic dneg;
		num[0] = sbhit_pkg::NUM_W'(bx) - $signed(sbhit_pkg::NUM_W'(mw)) - sbhit_pkg::NUM_W'(mx);
		num[1] = sbhit_pkg::NUM_W'(bx) + $signed(sbhit_pkg::NUM_W'(bw)) - sbhit_pkg::NUM_W'(mx);
		num[2] = sbhit_pkg::NUM_W'(by) - $signed(sbhit_pkg::NUM_W'(mh)) - sbhit_pkg::NUM_W'(my);
		num[3] = sbhit_pkg::NUM_W'(by) + $signed(sbhit_pkg::NUM_W'(bh)) - sbhit_pkg::NUM_W'(my);
		ud[0] = dx[sbhit_pkg::CW-1] ? sbhit_pkg::DW'(-dx) : sbhit_pkg::DW'(dx);
		ud[1] = dy[sbhit_pkg::CW-1] ? sbhit_pkg::DW'(-dy) : sbhit_pkg::DW'(dy);
		side.mx = mx;
		side.my = my;
		side.dx = dx;
		side.dy = dy;
		for (int k = 0; k < sbhit_pkg::NT; k++) begin
			dneg = (k < 2) ? dx[sbhit_pkg::CW-1] : dy[sbhit_pkg::CW-1];
			mag = num[k][sbhit_pkg::NUM_W-1] ? sbhit_pkg::AW'(-num[k]) : sbhit_pkg::AW'(num[k]);
			// magnitude scaled to time, plus half the divisor for round to nearest
			dvd[k] = sbhit_pkg::QW'({mag, {sbhit_pkg::TF{1'b0}}}) +
				sbhit_pkg::QW'(ud[k / 2] >> 1);
			side.ti[k].neg   = num[k][sbhit_pkg::NUM_W-1] != dneg;
			side.ti[k].dzero = (ud[k / 2] == '0);
			side.ti[k].nzero = (num[k] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= side;
			dvd_s1    <= dvd;
			dvs_s1[0] <= ud[0];
			dvs_s1[1] <= ud[1];
		end
	end

endmodule

/* rtl/sbhit_div_pipe.sv */
// ----------------------------------------------------------------------------
// sbhit_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sbhit_div_pipe (
	input  logic                       clk,
	input  logic                       en,
	input  logic [sbhit_pkg::QW-1:0]   dvd,
	input  logic [sbhit_pkg::DW-1:0]   dvs,
	output logic [sbhit_pkg::QW-1:0]   quo
);

	// dividend bits leave at the top while quotient bits enter at the bottom
	logic [sbhit_pkg::QW-1:0] acc_s [sbhit_pkg::QW+1];
	logic [sbhit_pkg::DW-1:0] rem_s [sbhit_pkg::QW+1];
	logic [sbhit_pkg::DW-1:0] dvs_s [sbhit_pkg::QW+1];

	assign acc_s[0] = dvd;
	assign rem_s[0] = '0;
	assign dvs_s[0] = dvs;

	for (genvar i = 0; i < sbhit_pkg::QW; i++) begin : g_stage
		logic [sbhit_pkg::DW:0] shifted;
		logic [sbhit_pkg::DW:0] diff;
		logic ge;

		always_comb begin
			shifted = {rem_s[i], acc_s[i][sbhit_pkg::QW-1]};
			diff    = shifted - {1'b0, dvs_s[i]};
			ge      = shifted >= {1'b0, dvs_s[i]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[sbhit_pkg::DW-1:0] : shifted[sbhit_pkg::DW-1:0];
				acc_s[i+1] <= {acc_s[i][sbhit_pkg::QW-2:0], ge};
				dvs_s[i+1] <= dvs_s[i];
			end
		end
	end

	assign quo = acc_s[sbhit_pkg::QW];

endmodule

/* rtl/sbhit_select.sv */
// ----------------------------------------------------------------------------
// sbhit_select
// Signed slab times, interval ordering, overlap test and face selection.
// ----------------------------------------------------------------------------
module sbhit_select (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         in_valid,
	input  sbhit_pkg::side_t                             side,
	input  logic [sbhit_pkg::NT-1:0][sbhit_pkg::QW-1:0]  quo,
	output logic                                         valid_s3,
	output sbhit_pkg::sel_t                              sel_s3
);

	logic valid_s2;
	logic bad_s2;
	sbhit_pkg::tval_t t_s2 [sbhit_pkg::NT];
	sbhit_pkg::side_t side_s2;

	sbhit_pkg::tval_t t_nx [sbhit_pkg::NT];
	logic bad;
	sbhit_pkg::sel_t sel;

	always_comb begin
		sbhit_pkg::tval_t q;
		bad = 1'b0;
		for (int k = 0; k < sbhit_pkg::NT; k++) begin
			q = $signed({3'b000, quo[k]});
			if (side.ti[k].dzero) begin
				bad = bad | side.ti[k].nzero;
				t_nx[k] = side.ti[k].neg ? -sbhit_pkg::T_INF : sbhit_pkg::T_INF;
			end else begin
				t_nx[k] = side.ti[k].neg ? -q : q;
			end
		end
	end

	always_comb begin
		sbhit_pkg::tval_t xlo, xhi, ylo, yhi, tnear, tfar;
		logic miss;
		xlo = (t_s2[0] > t_s2[1]) ? t_s2[1] : t_s2[0];
		xhi = (t_s2[0] > t_s2[1]) ? t_s2[0] : t_s2[1];
		ylo = (t_s2[2] > t_s2[3]) ? t_s2[3] : t_s2[2];
		yhi = (t_s2[2] > t_s2[3]) ? t_s2[2] : t_s2[3];
		tnear = (xlo > ylo) ? xlo : ylo;
		tfar  = (xhi < yhi) ? xhi : yhi;
		miss = bad_s2 || (xlo > yhi) || (ylo > xhi) || (tfar < 0) || (tnear > sbhit_pkg::T_ONE);
		sel.hit = !miss;
		sel.mx  = side_s2.mx;
		sel.my  = side_s2.my;
		sel.dx  = side_s2.dx;
		sel.dy  = side_s2.dy;
		if (tnear > sbhit_pkg::TH_MAX) begin
			sel.th = sbhit_pkg::TH_MAX[sbhit_pkg::TW-1:0];
		end else if (tnear < sbhit_pkg::TH_MIN) begin
			sel.th = sbhit_pkg::TH_MIN[sbhit_pkg::TW-1:0];
		end else begin
			sel.th = tnear[sbhit_pkg::TW-1:0];
		end
		// tie on entry times leaves the face undecided
		if (xlo > ylo) begin
			sel.normal = side_s2.dx[sbhit_pkg::CW-1] ? sbhit_pkg::NORM_POS_X : sbhit_pkg::NORM_NEG_X;
		end else if (xlo < ylo) begin
			sel.normal = side_s2.dy[sbhit_pkg::CW-1] ? sbhit_pkg::NORM_POS_Y : sbhit_pkg::NORM_NEG_Y;
		end else begin
			sel.normal = sbhit_pkg::NORM_NONE;
		end
		if (miss) begin
			sel.th     = '0;
			sel.normal = sbhit_pkg::NORM_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= t_nx;
			bad_s2  <= bad;
			side_s2 <= side;
			sel_s3  <= sel;
		end
	end

endmodule

/* rtl/sbhit_contact.sv */
// ----------------------------------------------------------------------------
// sbhit_contact
// Contact point: time times displacement, rounding, offset and clamp.
// ----------------------------------------------------------------------------
module sbhit_contact (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  sbhit_pkg::sel_t   sel,
	output logic              valid_s5,
	output sbhit_pkg::res_t   res_s5
);

	logic valid_s4;
	logic signed [sbhit_pkg::PW-1:0] px_s4, py_s4;
	sbhit_pkg::sel_t sel_s4;
	sbhit_pkg::res_t res;

	function automatic sbhit_pkg::coord_t place(sbhit_pkg::coord_t pos, logic dz,
		logic signed [sbhit_pkg::PW-1:0] p);
		logic [sbhit_pkg::PW-1:0] mag;
		logic [sbhit_pkg::PW:0] sum;
		logic signed [sbhit_pkg::RW-1:0] r;
		logic signed [sbhit_pkg::CS_W-1:0] c;
		mag = p[sbhit_pkg::PW-1] ? sbhit_pkg::PW'(-p) : sbhit_pkg::PW'(p);
		sum = {1'b0, mag} + (sbhit_pkg::PW+1)'(longint'(1) << (sbhit_pkg::TF - 1));
		r = $signed({1'b0, sum[sbhit_pkg::PW:sbhit_pkg::TF]});
		if (p[sbhit_pkg::PW-1]) begin
			r = -r;
		end
		c = sbhit_pkg::CS_W'(pos);
		if (!dz) begin
			c = c + sbhit_pkg::CS_W'(r);
		end
		if (c > sbhit_pkg::C_MAX) begin
			c = sbhit_pkg::C_MAX;
		end else if (c < sbhit_pkg::C_MIN) begin
			c = sbhit_pkg::C_MIN;
		end
		return c[sbhit_pkg::CW-1:0];
	endfunction

	always_comb begin
		res.hit    = sel_s4.hit;
		res.th     = sel_s4.th;
		res.normal = sel_s4.normal;
		res.cx     = '0;
		res.cy     = '0;
		if (sel_s4.hit) begin
			res.cx = place(sel_s4.mx, sel_s4.dx == '0, px_s4);
			res.cy = place(sel_s4.my, sel_s4.dy == '0, py_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4  <= sel.th * sel.dx;
			py_s4  <= sel.th * sel.dy;
			sel_s4 <= sel;
			res_s5 <= res;
		end
	end

endmodule

/* rtl/sbhit_checker.sv */
// ----------------------------------------------------------------------------
// sbhit_checker
// Port-level checks of the swept box hit test, bound to the top level.
// ----------------------------------------------------------------------------
module sbhit_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [sbhit_pkg::IN_W-1:0]    s_axis_tdata,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [sbhit_pkg::OUT_W-1:0]   m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

	// a miss reports all fields as zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[sbhit_pkg::OUT_W-1:1] == '0)
		else $error("miss with nonzero fields");

	// a hit's entry time is at most one step
	a_hit_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |->
		$signed(m_axis_tdata[24:1]) <= $signed(25'(longint'(1) << sbhit_pkg::TF)))
		else $error("hit time beyond one step");

endmodule

bind swept_box_vs_box_hit_test sbhit_checker u_sbhit_checker (.*);

/* tb/sv/tb_swept_box_vs_box_hit_test.sv */
// ----------------------------------------------------------------------------
// tb_swept_box_vs_box_hit_test
// Streams box pairs into the swept box hit test and compares every result
// against a slab-method predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_swept_box_vs_box_hit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint TINF = longint'(1) << 62;
	localparam longint CMAX = (longint'(1) << (sbhit_pkg::CW - 1)) - 1;
	localparam longint CMIN = -(longint'(1) << (sbhit_pkg::CW - 1));
	localparam longint TMAX = (longint'(1) << (sbhit_pkg::TW - 1)) - 1;
	localparam longint TMIN = -(longint'(1) << (sbhit_pkg::TW - 1));
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		longint mx, my, mw, mh, dx, dy, bx, by, bw, bh;
	} pair_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [sbhit_pkg::IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [sbhit_pkg::OUT_W-1:0] m_axis_tdata;

	sbhit_pkg::res_t expected_hits[$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 0;

	swept_box_vs_box_hit_test dut (.*);

	always #5 clk = ~clk;

	function automatic longint round_div(longint n, longint d);
		longint un, ud, q;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q = (un + ud / 2) / ud;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	// returns 0 for a zero step with zero numerator
	function automatic bit slab_time(longint num, longint d, output longint t);
		t = 0;
		if (d == 0) begin
			if (num == 0) return 0;
			t = num > 0 ? TINF : -TINF;
			return 1;
		end
		t = round_div(num * (longint'(1) << sbhit_pkg::TF), d);
		return 1;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint contact(longint p, longint d, longint t);
		longint c;
		c = p;
		if (d != 0) c += round_div(t * d, longint'(1) << sbhit_pkg::TF);
		return sat(c, CMIN, CMAX);
	endfunction

	function automatic sbhit_pkg::res_t predict_hit(pair_t p);
		sbhit_pkg::res_t r;
		longint nx, fx, ny, fy, tmp, tn, tf, th;
		r = '0;
		if (!slab_time(p.bx - p.mw - p.mx, p.dx, nx)) return r;
		if (!slab_time(p.bx + p.bw - p.mx, p.dx, fx)) return r;
		if (!slab_time(p.by - p.mh - p.my, p.dy, ny)) return r;
		if (!slab_time(p.by + p.bh - p.my, p.dy, fy)) return r;
		if (nx > fx) begin tmp = nx; nx = fx; fx = tmp; end
		if (ny > fy) begin tmp = ny; ny = fy; fy = tmp; end
		if (nx > fy || ny > fx) return r;
		tn = nx > ny ? nx : ny;
		tf = fx < fy ? fx : fy;
		if (tf < 0 || tn > (longint'(1) << sbhit_pkg::TF)) return r;
		th = sat(tn, TMIN, TMAX);
		r.hit = 1;
		r.th = sbhit_pkg::time_t'(th);
		r.cx = sbhit_pkg::coord_t'(contact(p.mx, p.dx, th));
		r.cy = sbhit_pkg::coord_t'(contact(p.my, p.dy, th));
		if (nx > ny) r.normal = p.dx < 0 ? sbhit_pkg::NORM_POS_X : sbhit_pkg::NORM_NEG_X;
		else if (nx < ny) r.normal = p.dy < 0 ? sbhit_pkg::NORM_POS_Y : sbhit_pkg::NORM_NEG_Y;
		else r.normal = sbhit_pkg::NORM_NONE;
		return r;
	endfunction

	function automatic bit idle_now();
		return !calm && $urandom_range(99) < 27;
	endfunction

	task automatic send_pair(pair_t p);
		logic [sbhit_pkg::IN_W-1:0] w;
		w = '0;
		w[0 +: 24] = p.mx[23:0];
		w[24 +: 24] = p.my[23:0];
		w[48 +: 23] = p.mw[22:0];
		w[71 +: 23] = p.mh[22:0];
		w[94 +: 24] = p.dx[23:0];
		w[118 +: 24] = p.dy[23:0];
		w[142 +: 24] = p.bx[23:0];
		w[166 +: 24] = p.by[23:0];
		w[190 +: 23] = p.bw[22:0];
		w[213 +: 23] = p.bh[22:0];
		while (idle_now()) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= w;
		expected_hits.insert(expected_hits.size(), predict_hit(p));
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic longint rand_coord(bit near_range);
		if (near_range) return longint'($urandom_range(8000)) - 4000;
		return longint'(signed'(24'($urandom)));
	endfunction

	function automatic pair_t rand_pair(int mode);
		pair_t p;
		bit nr;
		nr = mode != 0;
		p.mx = rand_coord(nr); p.my = rand_coord(nr);
		p.bx = rand_coord(nr); p.by = rand_coord(nr);
		p.mw = nr ? $urandom_range(2000) : $urandom & 23'h7fffff;
		p.mh = nr ? $urandom_range(2000) : $urandom & 23'h7fffff;
		p.bw = nr ? $urandom_range(2000) : $urandom & 23'h7fffff;
		p.bh = nr ? $urandom_range(2000) : $urandom & 23'h7fffff;
		// aim the step at the box in mode 2
		if (mode == 2) begin
			p.dx = p.bx - p.mx + longint'($urandom_range(400)) - 200;
			p.dy = p.by - p.my + longint'($urandom_range(400)) - 200;
		end else begin
			p.dx = rand_coord(nr); p.dy = rand_coord(nr);
		end
		if ($urandom_range(15) == 0) p.dx = 0;
		if ($urandom_range(15) == 0) p.dy = 0;
		return p;
	endfunction

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic test_directed();
		pair_t p;
		p = '{0, 0, 256, 256, 1024, 0, 512, 0, 256, 256}; send_pair(p);
		p = '{1024, 0, 256, 256, -1024, 0, 0, 0, 256, 256}; send_pair(p);
		p = '{0, 0, 256, 256, 0, 1024, 0, 512, 256, 256}; send_pair(p);
		p = '{0, 1024, 256, 256, 0, -1024, 0, 0, 256, 256}; send_pair(p);
		// diagonal corner hit, equal entry times
		p = '{0, 0, 256, 256, 1024, 1024, 512, 512, 256, 256}; send_pair(p);
		// zero step with zero numerator
		p = '{0, 0, 256, 256, 0, 100, 256, 0, 256, 256}; send_pair(p);
		// zero step, already inside
		p = '{0, 0, 256, 256, 0, 0, 0, 0, 512, 512}; send_pair(p);
		// zero step, outside
		p = '{0, 0, 256, 256, 0, 0, 4096, 4096, 256, 256}; send_pair(p);
		// moving away
		p = '{0, 0, 256, 256, -1024, 0, 512, 0, 256, 256}; send_pair(p);
		// too short a step
		p = '{0, 0, 256, 256, 10, 0, 5000, 0, 256, 256}; send_pair(p);
		// field extremes
		p = '{CMIN, CMIN, 0, 0, CMAX, CMAX, CMAX, CMAX, 8388607, 8388607}; send_pair(p);
		p = '{CMAX, CMAX, 8388607, 8388607, CMIN, CMIN, CMIN, CMIN, 0, 0}; send_pair(p);
		p = '{CMIN, CMAX, 8388607, 0, 1, -1, CMAX, CMIN, 8388607, 0}; send_pair(p);
		p = '{CMAX, CMIN, 0, 8388607, CMIN, CMAX, CMIN, CMAX, 0, 8388607}; send_pair(p);
		// large negative entry time saturates low
		p = '{0, 0, 256, 256, 1, 1, -CMAX, -CMAX, CMAX, CMAX}; send_pair(p);
		p = '{-1, -1, 1, 1, -1, -1, -1, -1, 1, 1}; send_pair(p);
		wait_drained();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 3 && i < count / 3 + 200);
			send_pair(rand_pair($urandom_range(2)));
			if (i == count / 2) wait_drained();
		end
		calm = 0;
	endtask

	// result side: random back pressure and comparison
	always @(posedge clk) begin
		sbhit_pkg::res_t got, want;
		m_axis_tready <= !idle_now();
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hit = m_axis_tdata[0];
			got.th = m_axis_tdata[1 +: 24];
			got.cx = m_axis_tdata[25 +: 24];
			got.cy = m_axis_tdata[49 +: 24];
			got.normal = m_axis_tdata[73 +: 3];
			if (expected_hits.size() == 0) begin
				$error("result transaction with no pair outstanding");
				errors++;
			end else begin
				want = expected_hits.pop_front();
				if (got.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
				end
				if (got.th !== want.th) begin
					$error("hit_time: expected %0d, got %0d", want.th, got.th); errors++;
				end
				if (got.cx !== want.cx) begin
					$error("contact_x: expected %0d, got %0d", want.cx, got.cx); errors++;
				end
				if (got.cy !== want.cy) begin
					$error("contact_y: expected %0d, got %0d", want.cy, got.cy); errors++;
				end
				if (got.normal !== want.normal) begin
					$error("normal_code: expected %0d, got %0d", want.normal, got.normal);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(1600);
		wait_drained();
		if (errors == 0 && expected_hits.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* sim.f */
rtl/sbhit_pkg.sv
rtl/sbhit_prep.sv
rtl/sbhit_div_pipe.sv
rtl/sbhit_select.sv
rtl/sbhit_contact.sv
rtl/swept_box_vs_box_hit_test.sv
rtl/sbhit_checker.sv
tb/sv/tb_swept_box_vs_box_hit_test.sv
